FILE: sv/sit_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the string intern table.
package sit_pkg;

  localparam int unsigned SLOTS      = 256;
  localparam int unsigned SLOT_W     = $clog2(SLOTS);
  localparam int unsigned PROBE_W    = SLOT_W + 1;
  localparam int unsigned MAX_LEN    = 32;
  localparam int unsigned CI_W       = $clog2(MAX_LEN);
  localparam int unsigned LEN_W      = 6;
  localparam int unsigned ID_W       = 8;
  localparam int unsigned CAP        = (SLOTS * 7) / 10;
  localparam int unsigned NAME_DEPTH = CAP * MAX_LEN;
  localparam int unsigned NADDR_W    = ID_W + CI_W;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_END    = 2'd1,
    ACT_READ   = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ERR_OK     = 2'd0,
    ERR_FULL   = 2'd1,
    ERR_LONG   = 2'd2,
    ERR_BAD_ID = 2'd3
  } err_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROBE_CHK,
    ST_LEN_CHK,
    ST_CMP,
    ST_COPY,
    ST_EMIT,
    ST_RLEN,
    ST_RBYTE
  } state_e;

  typedef struct packed {
    logic              is_end;
    logic [ID_W-1:0]   name_id;
    logic [SLOT_W-1:0] home;
    logic              overlong;
  } cmd_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic             is_new;
    err_e             error;
    logic [7:0]       name_byte;
    logic             byte_valid;
    logic [LEN_W-1:0] name_len;
    logic             last;
  } res_t;

  typedef struct packed {
    logic             key_locked;
    logic [LEN_W-1:0] key_len;
  } front_sts_t;

endpackage

FILE: sv/sit_cmd_fifo.sv
`timescale 1ns / 1ps
// Two-entry command queue between the front and the back.
module sit_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sit_pkg::cmd_t push_cmd_i,
  input  logic          pop_i,
  output sit_pkg::cmd_t pop_cmd_o,
  output logic          full_o,
  output logic          empty_o
);

  sit_pkg::cmd_t mem_q [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    wp_d  = push_i ? ~wp_q : wp_q;
    rp_d  = pop_i ? ~rp_q : rp_q;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= push_cmd_i;
    end
  end

  assign pop_cmd_o = mem_q[rp_q];
  assign full_o    = (cnt_q == 2'd2);
  assign empty_o   = (cnt_q == 2'd0);

endmodule

FILE: sv/sit_front.sv
`timescale 1ns / 1ps
// Front end: takes requests, buffers key bytes, keeps the FNV-1a hash, queues commands.
module sit_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_valid_i,
  output logic                      s_ready_o,
  input  sit_pkg::action_e          action_i,
  input  logic [7:0]                key_byte_i,
  input  logic [sit_pkg::ID_W-1:0]  name_id_i,
  output logic                      push_o,
  output sit_pkg::cmd_t             push_cmd_o,
  input  logic                      cmd_full_i,
  input  logic                      key_done_i,
  input  logic [sit_pkg::CI_W-1:0]  key_idx_i,
  output logic [7:0]                key_rd_o,
  output sit_pkg::front_sts_t       sts_o
);

  logic [7:0]                key_q [sit_pkg::MAX_LEN];
  logic [sit_pkg::LEN_W-1:0] len_q, len_d;
  logic                      long_q, long_d;
  logic [31:0]               hash_q, hash_d;
  logic                      lock_q, lock_d;
  logic                      acc, room;

  always_comb begin
    unique case (action_i)
      sit_pkg::ACT_APPEND: s_ready_o = !lock_q;
      sit_pkg::ACT_END:    s_ready_o = !lock_q && !cmd_full_i;
      sit_pkg::ACT_READ:   s_ready_o = !cmd_full_i;
      default:             s_ready_o = 1'b1;
    endcase
  end

  assign acc  = s_valid_i && s_ready_o;
  assign room = (len_q < sit_pkg::LEN_W'(sit_pkg::MAX_LEN));

  always_comb begin
    len_d  = len_q;
    long_d = long_q;
    hash_d = hash_q;
    lock_d = lock_q;
    push_o = 1'b0;
    if (acc && action_i == sit_pkg::ACT_APPEND) begin
      if (room) begin
        len_d  = len_q + 1'b1;
        hash_d = (hash_q ^ {24'd0, key_byte_i}) * sit_pkg::FNV_PRIME;
      end else begin
        long_d = 1'b1;
      end
    end
    if (acc && (action_i == sit_pkg::ACT_END || action_i == sit_pkg::ACT_READ)) begin
      push_o = 1'b1;
    end
    if (acc && action_i == sit_pkg::ACT_END) begin
      lock_d = 1'b1;
    end
    if (key_done_i) begin
      lock_d = 1'b0;
      len_d  = '0;
      long_d = 1'b0;
      hash_d = sit_pkg::FNV_BASIS;
    end
  end

  assign push_cmd_o.is_end   = (action_i == sit_pkg::ACT_END);
  assign push_cmd_o.name_id  = name_id_i;
  assign push_cmd_o.home     = hash_q[sit_pkg::SLOT_W-1:0];
  assign push_cmd_o.overlong = long_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      long_q <= 1'b0;
      hash_q <= sit_pkg::FNV_BASIS;
      lock_q <= 1'b0;
    end else begin
      len_q  <= len_d;
      long_q <= long_d;
      hash_q <= hash_d;
      lock_q <= lock_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && action_i == sit_pkg::ACT_APPEND && room) begin
      key_q[len_q[sit_pkg::CI_W-1:0]] <= key_byte_i;
    end
  end

  assign key_rd_o         = key_q[key_idx_i];
  assign sts_o.key_locked = lock_q;
  assign sts_o.key_len    = len_q;

endmodule

FILE: sv/sit_back.sv
`timescale 1ns / 1ps
// Back end: probes the slot table, compares and stores names, streams results.
module sit_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cmd_empty_i,
  input  sit_pkg::cmd_t             cmd_i,
  output logic                      pop_o,
  input  sit_pkg::front_sts_t       front_i,
  output logic [sit_pkg::CI_W-1:0]  key_idx_o,
  input  logic [7:0]                key_rd_i,
  output logic                      key_done_o,
  output logic                      m_valid_o,
  input  logic                      m_ready_i,
  output sit_pkg::res_t             m_res_o
);

  sit_pkg::state_e state_q, state_d;

  logic [sit_pkg::SLOT_W-1:0]  j_q, j_d;
  logic [sit_pkg::PROBE_W-1:0] n_q, n_d;
  logic [sit_pkg::ID_W-1:0]    idx_q, idx_d;
  logic [sit_pkg::ID_W-1:0]    rid_q, rid_d;
  logic [sit_pkg::CI_W-1:0]    ci_q, ci_d;
  logic [sit_pkg::LEN_W-1:0]   len_q, len_d;
  logic [sit_pkg::ID_W-1:0]    count_q, count_d;
  logic                        end_q, end_d;
  sit_pkg::res_t               res_q, res_d;
  logic                        out_v_q, out_v_d;
  sit_pkg::res_t               out_q, out_d;

  logic [sit_pkg::ID_W-1:0]  slot_mem [sit_pkg::SLOTS];
  logic                      slot_vld_q [sit_pkg::SLOTS];
  logic [sit_pkg::ID_W-1:0]  slot_rd_q;
  logic                      slot_vrd_q;
  logic [sit_pkg::LEN_W-1:0] len_mem [sit_pkg::CAP];
  logic [sit_pkg::LEN_W-1:0] len_rd_q;
  logic [7:0]                name_mem [sit_pkg::NAME_DEPTH];
  logic [7:0]                name_rd_q;

  logic [sit_pkg::ID_W-1:0] sid;
  logic emit_ok, key_empty, ci_key_last, ci_rd_last, probe_last, table_full;
  logic byte_eq, len_eq, bad_id, commit, name_we, out_load;

  assign sid         = slot_vrd_q ? slot_rd_q : '0;
  assign emit_ok     = !out_v_q || m_ready_i;
  assign key_empty   = (front_i.key_len == '0);
  assign ci_key_last = (sit_pkg::LEN_W'(ci_q) + 1'b1 == front_i.key_len);
  assign ci_rd_last  = (sit_pkg::LEN_W'(ci_q) + 1'b1 == len_q);
  assign probe_last  = (n_q == sit_pkg::PROBE_W'(sit_pkg::SLOTS - 1));
  assign table_full  = (9'(count_q) + 9'd1 > 9'(sit_pkg::CAP));
  assign byte_eq     = (name_rd_q == key_rd_i);
  assign len_eq      = (len_rd_q == front_i.key_len);
  assign bad_id      = (cmd_i.name_id == '0) || (cmd_i.name_id > count_q);
  assign key_idx_o   = ci_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sit_pkg::ST_IDLE: begin
        if (!cmd_empty_i) begin
          if (cmd_i.is_end) begin
            state_d = cmd_i.overlong ? sit_pkg::ST_EMIT : sit_pkg::ST_PROBE_CHK;
          end else begin
            state_d = bad_id ? sit_pkg::ST_EMIT : sit_pkg::ST_RLEN;
          end
        end
      end
      sit_pkg::ST_PROBE_CHK: begin
        if (sid == '0) begin
          state_d = (table_full || key_empty) ? sit_pkg::ST_EMIT : sit_pkg::ST_COPY;
        end else begin
          state_d = sit_pkg::ST_LEN_CHK;
        end
      end
      sit_pkg::ST_LEN_CHK: begin
        if (len_eq) begin
          state_d = key_empty ? sit_pkg::ST_EMIT : sit_pkg::ST_CMP;
        end else begin
          state_d = probe_last ? sit_pkg::ST_EMIT : sit_pkg::ST_PROBE_CHK;
        end
      end
      sit_pkg::ST_CMP: begin
        if (!byte_eq) begin
          state_d = probe_last ? sit_pkg::ST_EMIT : sit_pkg::ST_PROBE_CHK;
        end else if (ci_key_last) begin
          state_d = sit_pkg::ST_EMIT;
        end
      end
      sit_pkg::ST_COPY: begin
        if (ci_key_last) state_d = sit_pkg::ST_EMIT;
      end
      sit_pkg::ST_EMIT: begin
        if (emit_ok) state_d = sit_pkg::ST_IDLE;
      end
      sit_pkg::ST_RLEN: begin
        state_d = (len_rd_q == '0) ? sit_pkg::ST_EMIT : sit_pkg::ST_RBYTE;
      end
      sit_pkg::ST_RBYTE: begin
        if (emit_ok && ci_rd_last) state_d = sit_pkg::ST_IDLE;
      end
      default: state_d = sit_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    j_d      = j_q;
    n_d      = n_q;
    idx_d    = idx_q;
    rid_d    = rid_q;
    ci_d     = ci_q;
    len_d    = len_q;
    count_d  = count_q;
    end_d    = end_q;
    res_d    = res_q;
    out_d    = out_q;
    out_load = 1'b0;
    pop_o    = 1'b0;
    commit   = 1'b0;
    name_we  = 1'b0;
    key_done_o = 1'b0;
    unique case (state_q)
      sit_pkg::ST_IDLE: begin
        res_d = '0;
        res_d.last = 1'b1;
        if (!cmd_empty_i) begin
          pop_o = 1'b1;
          end_d = cmd_i.is_end;
          j_d   = cmd_i.home;
          n_d   = '0;
          rid_d = cmd_i.name_id;
          idx_d = cmd_i.name_id - 1'b1;
          if (cmd_i.is_end && cmd_i.overlong) res_d.error = sit_pkg::ERR_LONG;
          if (!cmd_i.is_end && bad_id) res_d.error = sit_pkg::ERR_BAD_ID;
        end
      end
      sit_pkg::ST_PROBE_CHK: begin
        if (sid == '0) begin
          if (table_full) begin
            res_d.error = sit_pkg::ERR_FULL;
          end else begin
            idx_d = count_q;
            ci_d  = '0;
            if (key_empty) commit = 1'b1;
          end
        end else begin
          idx_d = sid - 1'b1;
        end
      end
      sit_pkg::ST_LEN_CHK: begin
        ci_d = '0;
        if (len_eq) begin
          if (key_empty) res_d.id = idx_q + 1'b1;
        end else begin
          j_d = j_q + 1'b1;
          n_d = n_q + 1'b1;
          if (probe_last) res_d.error = sit_pkg::ERR_FULL;
        end
      end
      sit_pkg::ST_CMP: begin
        if (!byte_eq) begin
          j_d = j_q + 1'b1;
          n_d = n_q + 1'b1;
          if (probe_last) res_d.error = sit_pkg::ERR_FULL;
        end else if (ci_key_last) begin
          res_d.id = idx_q + 1'b1;
        end else begin
          ci_d = ci_q + 1'b1;
        end
      end
      sit_pkg::ST_COPY: begin
        name_we = 1'b1;
        if (ci_key_last) commit = 1'b1;
        else ci_d = ci_q + 1'b1;
      end
      sit_pkg::ST_EMIT: begin
        if (emit_ok) begin
          out_load   = 1'b1;
          out_d      = res_q;
          key_done_o = end_q;
        end
      end
      sit_pkg::ST_RLEN: begin
        len_d    = len_rd_q;
        ci_d     = '0;
        res_d.id = rid_q;
      end
      sit_pkg::ST_RBYTE: begin
        if (emit_ok) begin
          out_load         = 1'b1;
          out_d            = '0;
          out_d.id         = rid_q;
          out_d.name_byte  = name_rd_q;
          out_d.byte_valid = 1'b1;
          out_d.name_len   = len_q;
          out_d.last       = ci_rd_last;
          if (!ci_rd_last) ci_d = ci_q + 1'b1;
        end
      end
      default: ;
    endcase
    if (commit) begin
      count_d      = count_q + 1'b1;
      res_d.id     = count_q + 1'b1;
      res_d.is_new = 1'b1;
    end
    out_v_d = out_load || (out_v_q && !m_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sit_pkg::ST_IDLE;
      count_q <= '0;
      out_v_q <= 1'b0;
      for (int i = 0; i < int'(sit_pkg::SLOTS); i++) slot_vld_q[i] <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      out_v_q <= out_v_d;
      if (commit) slot_vld_q[j_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q   <= j_d;
    n_q   <= n_d;
    idx_q <= idx_d;
    rid_q <= rid_d;
    ci_q  <= ci_d;
    len_q <= len_d;
    end_q <= end_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  // memories: registered reads at the next-cycle address
  always_ff @(posedge clk_i) begin
    if (commit) slot_mem[j_q] <= count_q + 1'b1;
    slot_rd_q  <= slot_mem[j_d];
    slot_vrd_q <= slot_vld_q[j_d];
  end

  always_ff @(posedge clk_i) begin
    if (commit) len_mem[count_q] <= front_i.key_len;
    len_rd_q <= len_mem[idx_d];
  end

  always_ff @(posedge clk_i) begin
    if (name_we) name_mem[{idx_q, ci_q}] <= key_rd_i;
    name_rd_q <= name_mem[{idx_d, ci_d}];
  end

  assign m_valid_o = out_v_q;
  assign m_res_o   = out_q;

endmodule

FILE: sv/string_intern_table_top.sv
`timescale 1ns / 1ps
// Top level of the string intern table.
//
// Usage: requests enter on the s_axis channel; tuser carries the action
// (append key byte, end of key, read name by id), tdata the key byte and
// the name id. Results leave on m_axis, tlast marking the final result of
// a request. Appends give no result; end of key gives one result (id,
// is_new, error); a name read gives one result per stored byte, or one
// result for an empty name or a bad id.
// Rate: an append is taken every cycle while no key is locked. End of key
// waits for the command queue; the back end then takes the command, checks
// each probed slot, checks the length of each occupied slot, compares up to
// key length bytes per slot whose stored length matches, copies the key on
// insert, then loads the output register. A name read takes the command,
// reads the length, then sends one byte at a time. The single read port of
// each table memory and the one-byte-per-cycle compare loop set this pacing.
// Appends stall from an end of key until its result is issued.
// Reset clears the slot valid bits, id count, key length and hash at once;
// no clearing pass is needed. When m_axis_tready is low the output register
// holds, the back end waits, and the two-deep queue fills before
// s_axis_tready drops.
module string_intern_table_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // key_byte[7:0], name_id[15:8]
  input  logic [1:0]  s_axis_tuser,   // action[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // id[7:0], is_new[8], error[10:9],
                                      // name_byte[18:11], byte_valid[19],
                                      // name_len[25:20], zero[31:26]
  output logic        m_axis_tlast
);

  sit_pkg::cmd_t       push_cmd, pop_cmd;
  logic                cmd_push, cmd_pop, cmd_full, cmd_empty;
  logic                key_done;
  logic [sit_pkg::CI_W-1:0] key_idx;
  logic [7:0]          key_rd;
  sit_pkg::front_sts_t front_sts;
  sit_pkg::res_t       res;

  sit_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_o  (s_axis_tready),
    .action_i   (sit_pkg::action_e'(s_axis_tuser)),
    .key_byte_i (s_axis_tdata[7:0]),
    .name_id_i  (s_axis_tdata[15:8]),
    .push_o     (cmd_push),
    .push_cmd_o (push_cmd),
    .cmd_full_i (cmd_full),
    .key_done_i (key_done),
    .key_idx_i  (key_idx),
    .key_rd_o   (key_rd),
    .sts_o      (front_sts)
  );

  // decouples request intake from table work
  sit_cmd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (cmd_push),
    .push_cmd_i (push_cmd),
    .pop_i      (cmd_pop),
    .pop_cmd_o  (pop_cmd),
    .full_o     (cmd_full),
    .empty_o    (cmd_empty)
  );

  sit_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (pop_cmd),
    .pop_o       (cmd_pop),
    .front_i     (front_sts),
    .key_idx_o   (key_idx),
    .key_rd_i    (key_rd),
    .key_done_o  (key_done),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_res_o     (res)
  );

  assign m_axis_tdata = {6'd0, res.name_len, res.byte_valid, res.name_byte,
                         res.error, res.is_new, res.id};
  assign m_axis_tlast = res.last;

  // the queue is never pushed when full nor popped when empty
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_push && cmd_full)) else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_pop && cmd_empty)) else $error("command queue underflow");

  // a key finishes only while the front holds it locked
  a_done_locked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_done |-> front_sts.key_locked) else $error("key done without lock");

endmodule

FILE: dv/string_intern_table_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the string intern table top level.
module string_intern_table_top_tb;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] key_byte;
    logic [7:0] name_id;
  } req_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;

  string_intern_table_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Shadow copy of the table state.
  logic [7:0]       key_buf [sit_pkg::MAX_LEN];
  int unsigned      key_len;
  bit               key_overlong;
  logic [31:0]      key_hash;
  int unsigned      slot_ids [sit_pkg::SLOTS];
  logic [7:0]       stored_bytes [sit_pkg::CAP][sit_pkg::MAX_LEN];
  int unsigned      stored_len [sit_pkg::CAP];
  int unsigned      id_count;

  req_t           pending_reqs[$];
  sit_pkg::res_t  expected_res[$];
  int             errors;
  int             tx_idle_pct, rx_idle_pct;
  bit             hold_tx;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic sit_pkg::res_t mk_res(int unsigned id, bit nw, sit_pkg::err_e e,
                                           logic [7:0] b, bit v, int unsigned len,
                                           bit lst);
    sit_pkg::res_t r;
    r.id         = sit_pkg::ID_W'(id);
    r.is_new     = nw;
    r.error      = e;
    r.name_byte  = b;
    r.byte_valid = v;
    r.name_len   = sit_pkg::LEN_W'(len);
    r.last       = lst;
    return r;
  endfunction

  function automatic void clear_key();
    key_len = 0;
    key_overlong = 1'b0;
    key_hash = sit_pkg::FNV_BASIS;
  endfunction

  // Predict the results of one accepted request and update the shadow state.
  function automatic void intern_predict(req_t q);
    int unsigned j, n, sid, k;
    bit hit;
    case (sit_pkg::action_e'(q.action))
      sit_pkg::ACT_APPEND: begin
        if (key_len < sit_pkg::MAX_LEN) begin
          key_buf[key_len] = q.key_byte;
          key_len++;
          key_hash = (key_hash ^ {24'd0, q.key_byte}) * sit_pkg::FNV_PRIME;
        end else begin
          key_overlong = 1'b1;
        end
      end
      sit_pkg::ACT_END: begin
        if (key_overlong) begin
          expected_res.push_back(mk_res(0, 1'b0, sit_pkg::ERR_LONG, 8'h00, 1'b0, 0, 1'b1));
        end else begin
          j = key_hash % sit_pkg::SLOTS;
          hit = 1'b0;
          for (n = 0; n < sit_pkg::SLOTS; n++) begin
            sid = slot_ids[j];
            if (sid == 0) break;
            if (sid <= id_count && stored_len[sid-1] == key_len) begin
              hit = 1'b1;
              for (k = 0; k < key_len; k++)
                if (stored_bytes[sid-1][k] != key_buf[k]) hit = 1'b0;
              if (hit) break;
            end
            j = (j + 1) % sit_pkg::SLOTS;
          end
          if (hit) begin
            expected_res.push_back(mk_res(sid, 1'b0, sit_pkg::ERR_OK, 8'h00, 1'b0, 0, 1'b1));
          end else if (n == sit_pkg::SLOTS || id_count + 1 > sit_pkg::CAP) begin
            expected_res.push_back(mk_res(0, 1'b0, sit_pkg::ERR_FULL, 8'h00, 1'b0, 0, 1'b1));
          end else begin
            for (k = 0; k < key_len; k++) stored_bytes[id_count][k] = key_buf[k];
            stored_len[id_count] = key_len;
            id_count++;
            slot_ids[j] = id_count;
            expected_res.push_back(mk_res(id_count, 1'b1, sit_pkg::ERR_OK, 8'h00, 1'b0, 0,
                                          1'b1));
          end
        end
        clear_key();
      end
      sit_pkg::ACT_READ: begin
        if (q.name_id == 0 || q.name_id > id_count) begin
          expected_res.push_back(mk_res(0, 1'b0, sit_pkg::ERR_BAD_ID, 8'h00, 1'b0, 0, 1'b1));
        end else if (stored_len[q.name_id-1] == 0) begin
          expected_res.push_back(mk_res(q.name_id, 1'b0, sit_pkg::ERR_OK, 8'h00, 1'b0, 0,
                                        1'b1));
        end else begin
          for (k = 0; k < stored_len[q.name_id-1]; k++)
            expected_res.push_back(mk_res(q.name_id, 1'b0, sit_pkg::ERR_OK,
              stored_bytes[q.name_id-1][k], 1'b1, stored_len[q.name_id-1],
              k + 1 == stored_len[q.name_id-1]));
        end
      end
      default: ;
    endcase
  endfunction

  // Driver: one request per handshake, next one presented in the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        intern_predict({s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[15:8]});
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_reqs.size() > 0 && !hold_tx &&
            $urandom_range(99, 0) >= tx_idle_pct) begin
          req_t q;
          q = pending_reqs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= q.action;
          s_axis_tdata  <= {q.name_id, q.key_byte};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result with the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        sit_pkg::res_t got;
        got = {m_axis_tdata[7:0], m_axis_tdata[8], m_axis_tdata[10:9],
               m_axis_tdata[18:11], m_axis_tdata[19], m_axis_tdata[25:20],
               m_axis_tlast};
        if (expected_res.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %h", $time, got);
        end else begin
          sit_pkg::res_t exp_r;
          exp_r = expected_res.pop_front();
          if (got !== exp_r || m_axis_tdata[31:26] !== 6'd0) begin
            errors++;
            $display("%0t: mismatch exp id=%0d new=%0b err=%0d byte=%h v=%0b len=%0d last=%0b",
                     $time, exp_r.id, exp_r.is_new, exp_r.error, exp_r.name_byte,
                     exp_r.byte_valid, exp_r.name_len, exp_r.last);
            $display("%0t:          got id=%0d new=%0b err=%0d byte=%h v=%0b len=%0d last=%0b",
                     $time, got.id, got.is_new, got.error, got.name_byte,
                     got.byte_valid, got.name_len, got.last);
          end
        end
      end
      m_axis_tready <= ($urandom_range(99, 0) >= rx_idle_pct);
    end
  end

  function automatic void push_req(sit_pkg::action_e a, logic [7:0] kb, logic [7:0] nid);
    req_t q;
    q.action = a; q.key_byte = kb; q.name_id = nid;
    pending_reqs.push_back(q);
  endfunction

  function automatic void push_key(int unsigned len, bit pick_small);
    for (int unsigned i = 0; i < len; i++)
      push_req(sit_pkg::ACT_APPEND,
               pick_small ? 8'($urandom_range(3, 0)) : 8'($urandom_range(255, 0)),
               8'($urandom_range(255, 0)));
    push_req(sit_pkg::ACT_END, 8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)));
  endfunction

  task automatic drain();
    while (pending_reqs.size() > 0 || s_axis_tvalid || expected_res.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    int unsigned r;
    errors = 0;
    hold_tx = 1'b0;
    tx_idle_pct = 9;
    rx_idle_pct = 72;
    for (int i = 0; i < sit_pkg::SLOTS; i++) slot_ids[i] = 0;
    id_count = 0;
    clear_key();
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty key, full-width bytes, repeat lookup, reads, overlong, noise.
    push_req(sit_pkg::ACT_READ, 8'h00, 8'h00);        // bad id zero
    push_req(sit_pkg::ACT_END, 8'h00, 8'h00);         // empty key -> id 1
    push_req(sit_pkg::ACT_END, 8'hff, 8'hff);         // empty key found again
    push_req(sit_pkg::ACT_APPEND, 8'h00, 8'h00);
    push_req(sit_pkg::ACT_APPEND, 8'hff, 8'h00);
    push_req(sit_pkg::ACT_APPEND, 8'hAA, 8'hff);
    push_req(sit_pkg::ACT_END, 8'h00, 8'h00);         // new id 2
    push_req(sit_pkg::ACT_READ, 8'h00, 8'd2);
    push_req(sit_pkg::ACT_READ, 8'h00, 8'd1);         // empty name
    push_req(sit_pkg::ACT_READ, 8'h00, 8'd179);       // bad id high
    push_req(sit_pkg::ACT_NONE, 8'h55, 8'h55);        // ignored
    for (int i = 0; i < sit_pkg::MAX_LEN + 2; i++)
      push_req(sit_pkg::ACT_APPEND, 8'h55, 8'h00);
    push_req(sit_pkg::ACT_END, 8'h00, 8'h00);         // overlong
    drain();

    // Full-length key; the sender holds once the end of key is out until all results are in.
    for (int i = 0; i < sit_pkg::MAX_LEN; i++)
      push_req(sit_pkg::ACT_APPEND, 8'(255 - i), 8'h00);
    push_req(sit_pkg::ACT_END, 8'h00, 8'h00);
    push_req(sit_pkg::ACT_READ, 8'h00, 8'd3);
    while (pending_reqs.size() > 1) @(posedge clk_i);
    hold_tx = 1'b1;
    while (s_axis_tvalid || expected_res.size() > 0) @(posedge clk_i);
    hold_tx = 1'b0;
    drain();

    // Random: mostly short keys with a small alphabet for repeats.
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 9 : (ph == 1) ? 72 : 0;
      rx_idle_pct = (ph == 0) ? 72 : (ph == 1) ? 9 : 0;
      while (pending_reqs.size() < 9) begin
        r = $urandom_range(9, 0);
        if (r < 5) push_key($urandom_range(3, 0), 1'b1);
        else if (r < 7) push_key($urandom_range(6, 0), 1'b0);
        else if (r < 9) push_req(sit_pkg::ACT_READ, 8'($urandom_range(255, 0)),
                                 8'($urandom_range(id_count + 3, 0)));
        else push_req(sit_pkg::ACT_NONE, 8'($urandom_range(255, 0)),
                      8'($urandom_range(255, 0)));
      end
      drain();
    end

    repeat (100) @(posedge clk_i);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: string_intern_table_top.f
sv/sit_pkg.sv
sv/sit_cmd_fifo.sv
sv/sit_front.sv
sv/sit_back.sv
sv/string_intern_table_top.sv
dv/string_intern_table_top_tb.sv
